FILE: hdl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the stable min priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   // result status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_POPPED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int KEY_BITS = 32;
   localparam int REQ_PRIO_BITS = 16;
   localparam int OCC_BITS = 5;

   typedef struct packed {
      logic                             action;
      logic signed [REQ_PRIO_BITS-1:0]  priority_req;
      logic signed [KEY_BITS-1:0]       payload_key;
   } req_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic signed [KEY_BITS-1:0]  popped_key;
      logic [OCC_BITS-1:0]         occupancy;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic        load;    // capture a result
      logic        push;    // insert the request entry
      logic        pull;    // remove the head entry
      logic [1:0]  status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } flags_type;

endpackage : smpq_pkg

`default_nettype wire

FILE: hdl/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// Handshake control and request decode for the priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_action,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire smpq_pkg::flags_type flags,
   output smpq_pkg::cmd_type        cmd
);
   import smpq_pkg::*;

   typedef enum logic [1:0] {
      CS_IDLE = 2'b01,
      CS_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign rsp_valid = (state_ff == CS_HOLD);
   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) state_in = CS_HOLD;
         end
         CS_HOLD: begin
            if (!accept && !rsp_stall) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      if (req_action == ACT_INSERT) begin
         cmd.push   = accept && !flags.full;
         cmd.status = flags.full ? ST_FULL : ST_INSERTED;
      end else begin
         cmd.pull   = accept && !flags.empty;
         cmd.status = flags.empty ? ST_EMPTY : ST_POPPED;
      end
   end

endmodule : smpq_ctrl

`default_nettype wire

FILE: hdl/smpq_dp.sv
// ----------------------------------------------------------------------------
// smpq_dp
// Sorted slot array with parallel compare-and-shift, fill count, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpq_dp #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire smpq_pkg::req_type   req,
   input  wire smpq_pkg::cmd_type   cmd,
   output smpq_pkg::flags_type      flags,
   output smpq_pkg::rsp_type        rsp
);
   import smpq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [PRIO_BITS-1:0] prio_ff [DEPTH];
   logic signed [KEY_BITS-1:0]  key_ff  [DEPTH];
   logic [CW-1:0]               fill_ff, fill_in;
   logic [DEPTH-1:0]            le;     // slot stays ahead of the new entry
   logic signed [PRIO_BITS-1:0] new_prio;
   rsp_type                     rsp_ff, rsp_in;

   // sign-extend or wrap to the stored width
   assign new_prio = PRIO_BITS'($signed(req.priority_req));

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CW'(i) < fill_ff) && (prio_ff[i] <= new_prio);
      end
   end

   genvar g;
   for (g = 0; g < DEPTH; g++) begin : g_slot
      logic signed [PRIO_BITS-1:0] up_prio, dn_prio;
      logic signed [KEY_BITS-1:0]  up_key, dn_key;
      logic                        take_new;

      if (g == 0) begin : g_first
         assign up_prio  = new_prio;
         assign up_key   = req.payload_key;
         assign take_new = 1'b1;
      end else begin : g_rest
         assign up_prio  = prio_ff[g-1];
         assign up_key   = key_ff[g-1];
         assign take_new = le[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign dn_prio = prio_ff[g];
         assign dn_key  = key_ff[g];
      end else begin : g_mid
         assign dn_prio = prio_ff[g+1];
         assign dn_key  = key_ff[g+1];
      end

      always_ff @(posedge clock) begin
         if (cmd.push && !le[g]) begin
            prio_ff[g] <= take_new ? new_prio : up_prio;
            key_ff[g]  <= take_new ? req.payload_key : up_key;
         end else if (cmd.pull) begin
            prio_ff[g] <= dn_prio;
            key_ff[g]  <= dn_key;
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push)      fill_in = fill_ff + 1'b1;
      else if (cmd.pull) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   assign flags.full  = (fill_ff == CW'(DEPTH));
   assign flags.empty = (fill_ff == '0);

   always_comb begin
      rsp_in            = rsp_ff;
      if (cmd.load) begin
         rsp_in.status     = cmd.status;
         rsp_in.popped_key = cmd.pull ? key_ff[0] : '0;
         rsp_in.occupancy  = OCC_BITS'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_ff <= '0;
      else       rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule : smpq_dp

`default_nettype wire

FILE: hdl/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue: bounded sorted queue, lowest priority served first
// A request's result is in the output register the cycle after it is accepted.
// Throughput 1 request per cycle while rsp_stall does not hold the pending result.
// Sync reset empties the queue and the output register; slot data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue #(
   parameter int DEPTH     = 16,   // slot count, 2..31 (occupancy is OCC_BITS wide)
   parameter int PRIO_BITS = 16    // stored priority width, 1..32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire smpq_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output smpq_pkg::rsp_type       rsp_payload
);
   import smpq_pkg::*;

   // Controller owns the handshake; the datapath holds the sorted slots.
   // An insert compares every live slot against the new priority at once:
   // slots with priority <= new stay, the first one after them takes the
   // new entry, the rest shift back one place. Equal priorities therefore
   // keep arrival order. A pop shifts every slot forward one place.
   cmd_type   cmd;
   flags_type flags;

   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_payload.action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .flags      (flags),
      .cmd        (cmd)
   );

   // The output register is loaded on every accepted request; a new request
   // is taken as long as the pending result leaves in the same cycle.
   smpq_dp #(
      .DEPTH     (DEPTH),
      .PRIO_BITS (PRIO_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_payload),
      .cmd   (cmd),
      .flags (flags),
      .rsp   (rsp_payload)
   );

`ifndef SYNTHESIS
   // a pop request always yields a pop-class status, an insert an insert-class
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=>
         (($past(req_payload.action) == ACT_POP) ==
          (rsp_payload.status == ST_POPPED || rsp_payload.status == ST_EMPTY)))
      else $error("status class does not match request action");

   // empty report only with nothing stored
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_EMPTY) |-> (rsp_payload.occupancy == '0))
      else $error("pop on empty with nonzero occupancy");

   // full rejection only at capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FULL) |->
         (rsp_payload.occupancy == OCC_BITS'(DEPTH)))
      else $error("insert rejected below capacity");

   // key is zero unless an entry was actually removed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_POPPED) |-> (rsp_payload.popped_key == '0))
      else $error("nonzero key without a pop");
`endif

endmodule : stable_min_priority_queue

`default_nettype wire
